@@ src/wavp_pkg.sv @@
// Shared types and constants for the WAV PCM stream parser.
// Holds the request and result structs, result kinds, error codes and chunk tags.
// No dependencies.
`default_nettype none

package wavp_pkg;

	// one byte of the incoming file
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_file;
	} wav_in_t;

	// one result item
	typedef struct packed {
		logic [1:0]        kind;
		logic signed [15:0] sample;
		logic [31:0]       sample_rate;
		logic [7:0]        channel_count;
		logic [7:0]        sample_bits;
		logic [2:0]        error_code;
		logic              last;
	} wav_out_t;

	// result kinds
	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_INFO   = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;
	localparam logic [1:0] KIND_END    = 2'd3;

	// error codes
	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_RIFF    = 3'd1;
	localparam logic [2:0] ERR_NO_FMT  = 3'd2;
	localparam logic [2:0] ERR_NOT_PCM = 3'd3;
	localparam logic [2:0] ERR_NO_DATA = 3'd4;
	localparam logic [2:0] ERR_DEPTH   = 3'd5;

	// chunk tags, first byte in the top bits
	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	localparam logic [15:0] FMT_PCM      = 16'd1;
	localparam logic [31:0] FMT_BASE_LEN = 32'd16;
	localparam logic [15:0] DEPTH_8      = 16'd8;
	localparam logic [15:0] DEPTH_16     = 16'd16;

endpackage

`default_nettype wire

@@ src/wavp_parse.sv @@
// Parser state machine of the WAV PCM stream parser: one byte per step.
// Produces at most one result per byte, combinationally from the held state.
// Depends on wavp_pkg.
`default_nettype none

module wavp_parse (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire wavp_pkg::wav_in_t item,
	output logic                   res_fire,
	output wavp_pkg::wav_out_t     res
);
	import wavp_pkg::*;

	typedef enum logic [2:0] {
		PH_HDR, PH_FMT, PH_SKIP, PH_CHUNK, PH_DATA, PH_DONE, PH_ERR
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [4:0]  cnt_q, cnt_d;
	logic [31:0] tag_q, tag_d;
	logic [31:0] len_q, len_d;
	logic [31:0] btg_q, btg_d;
	logic [15:0] fmt_q, fmt_d;
	logic [7:0]  chan_q, chan_d;
	logic [31:0] rate_q, rate_d;
	logic [15:0] depth_q, depth_d;
	logic [7:0]  low_q, low_d;
	logic        tag_ok_q, tag_ok_d;

	logic [7:0]  b;
	logic [4:0]  c;
	logic        depth_ok;

	// little-endian byte insert; byte 0 restarts the field
	function automatic logic [31:0] le_put32(logic [31:0] acc, logic [7:0] byt,
		logic [1:0] pos);
		logic [31:0] r;
		begin
			case (pos)
				2'd0:    r = {24'd0, byt};
				2'd1:    r = acc | {16'd0, byt, 8'd0};
				2'd2:    r = acc | {8'd0, byt, 16'd0};
				default: r = acc | {byt, 24'd0};
			endcase
			return r;
		end
	endfunction

	function automatic logic [15:0] le_put16(logic [15:0] acc, logic [7:0] byt,
		logic pos);
		logic [15:0] r;
		begin
			r = pos ? (acc | {byt, 8'd0}) : {8'd0, byt};
			return r;
		end
	endfunction

	assign b        = item.data_byte;
	assign c        = cnt_q;
	assign depth_ok = (depth_q == DEPTH_8) || (depth_q == DEPTH_16);

	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		tag_d    = tag_q;
		len_d    = len_q;
		btg_d    = btg_q;
		fmt_d    = fmt_q;
		chan_d   = chan_q;
		rate_d   = rate_q;
		depth_d  = depth_q;
		low_d    = low_q;
		tag_ok_d = tag_ok_q;
		res_fire = 1'b0;
		res      = '0;

		case (phase_q)
			PH_HDR: begin
				if (c < 5'd4 || c >= 5'd8) tag_d = {tag_q[23:0], b};
				if (c == 5'd3) tag_ok_d = (tag_d == TAG_RIFF);
				if (c >= 5'd11) begin
					cnt_d = '0;
					if (tag_ok_q && tag_d == TAG_WAVE) begin
						phase_d = PH_FMT;
						tag_d   = '0;
					end else begin
						res_fire       = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_RIFF;
						phase_d        = PH_ERR;
					end
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			PH_FMT: begin
				if (c < 5'd4) tag_d = {tag_q[23:0], b};
				else if (c < 5'd8) len_d = le_put32(len_q, b, c[1:0]);
				else if (c < 5'd10) fmt_d = le_put16(fmt_q, b, c[0]);
				else if (c < 5'd12) begin
					if (c == 5'd10) chan_d = b;
				end
				else if (c < 5'd16) rate_d = le_put32(rate_q, b, c[1:0]);
				else if (c >= 5'd22) depth_d = le_put16(depth_q, b, c[0]);
				if (c >= 5'd23) begin
					cnt_d = '0;
					if (tag_d != TAG_FMT) begin
						res_fire       = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_NO_FMT;
						phase_d        = PH_ERR;
					end else if (fmt_d != FMT_PCM) begin
						res_fire       = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_NOT_PCM;
						phase_d        = PH_ERR;
					end else if (len_d > FMT_BASE_LEN) begin
						btg_d   = len_d - FMT_BASE_LEN;
						phase_d = PH_SKIP;
					end else begin
						phase_d = PH_CHUNK;
					end
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			PH_SKIP: begin
				if (btg_q != '0) btg_d = btg_q - 32'd1;
				if (btg_d == '0) begin
					phase_d = PH_CHUNK;
					cnt_d   = '0;
				end
			end
			PH_CHUNK: begin
				if (c < 5'd4) tag_d = {tag_q[23:0], b};
				else len_d = le_put32(len_q, b, c[1:0]);
				if (c >= 5'd7) begin
					cnt_d = '0;
					if (tag_d == TAG_DATA) begin
						res_fire = 1'b1;
						if (depth_ok) begin
							res.kind          = KIND_INFO;
							res.sample_rate   = rate_q;
							res.channel_count = chan_q;
							res.sample_bits   = depth_q[7:0];
							btg_d             = len_d;
							phase_d           = (len_d == '0) ? PH_DONE : PH_DATA;
						end else begin
							res.kind       = KIND_ERROR;
							res.error_code = ERR_DEPTH;
							phase_d        = PH_ERR;
						end
					end else if (len_d != '0) begin
						btg_d   = len_d;
						phase_d = PH_SKIP;
					end
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			PH_DATA: begin
				if (btg_q != '0) btg_d = btg_q - 32'd1;
				if (depth_q == DEPTH_8) begin
					// unsigned 8-bit to signed 16-bit: flip the sign bit, scale by 256
					res_fire   = 1'b1;
					res.kind   = KIND_SAMPLE;
					res.sample = {~b[7], b[6:0], 8'd0};
				end else if (c == 5'd0) begin
					low_d = b;
					cnt_d = 5'd1;
				end else begin
					res_fire   = 1'b1;
					res.kind   = KIND_SAMPLE;
					res.sample = {b, low_q};
					cnt_d      = '0;
				end
				if (btg_d == '0) begin
					phase_d = PH_DONE;
					cnt_d   = '0;
				end
			end
			default: begin
			end
		endcase

		if (item.end_of_file) begin
			// the last byte always reports; format info gives way to the closing item
			if (!res_fire || res.kind == KIND_INFO) begin
				res = '0;
				case (phase_d)
					PH_HDR: begin
						res.kind       = KIND_ERROR;
						res.error_code = ERR_RIFF;
					end
					PH_FMT: begin
						res.kind       = KIND_ERROR;
						res.error_code = ERR_NO_FMT;
					end
					PH_SKIP, PH_CHUNK: begin
						res.kind       = KIND_ERROR;
						res.error_code = ERR_NO_DATA;
					end
					default: res.kind = KIND_END;
				endcase
			end
			res_fire = 1'b1;
			res.last = 1'b1;
			// return to the start for the next file
			phase_d  = PH_HDR;
			cnt_d    = '0;
			tag_d    = '0;
			len_d    = '0;
			btg_d    = '0;
			fmt_d    = '0;
			chan_d   = '0;
			rate_d   = '0;
			depth_d  = '0;
			low_d    = '0;
			tag_ok_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR;
			cnt_q    <= '0;
			tag_q    <= '0;
			len_q    <= '0;
			btg_q    <= '0;
			fmt_q    <= '0;
			chan_q   <= '0;
			rate_q   <= '0;
			depth_q  <= '0;
			low_q    <= '0;
			tag_ok_q <= 1'b1;
		end else if (step) begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			tag_q    <= tag_d;
			len_q    <= len_d;
			btg_q    <= btg_d;
			fmt_q    <= fmt_d;
			chan_q   <= chan_d;
			rate_q   <= rate_d;
			depth_q  <= depth_d;
			low_q    <= low_d;
			tag_ok_q <= tag_ok_d;
		end
	end

endmodule

`default_nettype wire

@@ src/wav_pcm_stream_parser.sv @@
// Top level of the WAV PCM stream parser: input register, parser, result register.
// Depends on wavp_pkg and wavp_parse.
//
//   channel | valid        | ready        | payload
//   --------+--------------+--------------+-------------------------------------
//   bytes   | byte_valid   | byte_ready   | byte_req (wav_in_t: byte, last flag)
//   results | result_valid | result_ready | result   (wav_out_t)
//
// One byte per cycle sustained while results are taken. A byte is held in the input
// register and its result, if any, is loaded into the result register when the byte
// advances through the parser.
// A byte that yields no result still passes the parser in its own cycle.
// A stalled result holds the result register; the input register takes one
// more request, then byte_ready drops until the result is taken.
// Reset returns the parser to the start of a file and empties both registers.
`default_nettype none

module wav_pcm_stream_parser (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              byte_valid,
	output logic                   byte_ready,
	input  wire wavp_pkg::wav_in_t byte_req,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output wavp_pkg::wav_out_t     result
);
	import wavp_pkg::*;

	// input register
	logic     valid_s1;
	wav_in_t  item_s1;

	// result register
	logic     valid_s2;
	wav_out_t res_s2;

	logic     advance;
	logic     res_fire;
	wav_out_t res_c;

	// move the held request through the parser whenever the result slot is free
	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	// payload register: load on accept, hold otherwise
	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			item_s1 <= byte_req;
		end
	end

	wavp_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.item     (item_s1),
		.res_fire (res_fire),
		.res      (res_c)
	);

	// drop the result slot when taken unless a new result lands in it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result_ready) begin
			valid_s2 <= advance && res_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_fire) begin
			res_s2 <= res_c;
		end
	end

	assign result_valid = valid_s2;
	assign result       = res_s2;

endmodule

`default_nettype wire

@@ src/wavp_checker.sv @@
// Port checker for the WAV PCM stream parser, bound to the top level.
// Depends on wavp_pkg and wav_pcm_stream_parser.
`default_nettype none

module wavp_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              byte_valid,
	input wire logic              byte_ready,
	input wire wavp_pkg::wav_in_t byte_req,
	input wire logic              result_valid,
	input wire logic              result_ready,
	input wire wavp_pkg::wav_out_t result
);
	import wavp_pkg::*;

	// hold a waiting request
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_ready |=> byte_valid && $stable(byte_req))
		else $error("request changed while waiting");

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// format info never closes a file
	a_info_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_INFO |-> !result.last)
		else $error("format info marked last");

	// format info only reports supported depths
	a_info_depth: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_INFO |->
			result.sample_bits == 8'd8 || result.sample_bits == 8'd16)
		else $error("format info with unsupported depth");

	// an error item carries a code, other items carry none
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((result.kind == KIND_ERROR) == (result.error_code != ERR_NONE)))
		else $error("error code does not match result kind");

endmodule

bind wav_pcm_stream_parser wavp_checker u_wavp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.byte_valid   (byte_valid),
	.byte_ready   (byte_ready),
	.byte_req     (byte_req),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for the WAV PCM stream parser (wav_pcm_stream_parser).
// Streams whole WAV files byte by byte and checks every result against a built-in parser model.
// Depends on wavp_pkg and the parser RTL.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import wavp_pkg::*;

	// parser position inside the file
	typedef enum logic [3:0] {
		ST_HEADER, ST_FORMAT, ST_SKIP, ST_CHUNK_HDR, ST_DATA, ST_DONE, ST_ERROR
	} parse_state_t;

	logic     clk          = 1'b0;
	logic     arst_n       = 1'b0;
	logic     byte_valid   = 1'b0;
	logic     byte_ready;
	wav_in_t  byte_req     = '0;
	logic     result_valid;
	logic     result_ready = 1'b0;
	wav_out_t result;

	wav_pcm_stream_parser u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_ready  (byte_ready),
		.byte_req    (byte_req),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Parser model: its own copy of the parse state, advanced once per
	// accepted request.
	// ------------------------------------------------------------------
	parse_state_t st;
	logic [4:0]   field_cnt;
	logic [31:0]  tag_sr;
	logic [31:0]  len_acc;
	logic [31:0]  remain;
	logic [15:0]  fmt_code;
	logic [15:0]  chan_cnt;
	logic [31:0]  rate_val;
	logic [15:0]  bits_val;
	logic [7:0]   low_byte;
	logic         riff_seen;

	function automatic void clear_parse_state();
		st        = ST_HEADER;
		field_cnt = '0;
		tag_sr    = '0;
		len_acc   = '0;
		remain    = '0;
		fmt_code  = '0;
		chan_cnt  = '0;
		rate_val  = '0;
		bits_val  = '0;
		low_byte  = '0;
		riff_seen = 1'b1;
	endfunction

	// Merge one little-endian byte; position 0 starts the field afresh.
	function automatic logic [31:0] place_byte(input logic [31:0] acc, input logic [7:0] b,
			input int pos);
		if (pos == 0)
			return {24'h0, b};
		acc[8*pos +: 8] = b;
		return acc;
	endfunction

	// Advance the model by one byte; return 1 and fill r when the byte yields a result.
	function automatic bit predict_result(input logic [7:0] b, input logic eof,
			output wav_out_t r);
		logic [4:0]  c;
		logic [31:0] tmp;
		bit          got;
		c   = field_cnt;
		got = 1'b0;
		r   = '0;
		case (st)
			ST_HEADER: begin
				// length bytes 4..7 are not part of either tag
				if (c < 4 || c >= 8)
					tag_sr = {tag_sr[23:0], b};
				if (c == 3)
					riff_seen = (tag_sr == TAG_RIFF);
				if (c >= 11) begin
					field_cnt = '0;
					if (riff_seen && tag_sr == TAG_WAVE) begin
						st     = ST_FORMAT;
						tag_sr = '0;
					end else begin
						got = 1'b1; r.kind = KIND_ERROR; r.error_code = ERR_RIFF;
						st  = ST_ERROR;
					end
				end else
					field_cnt = c + 5'd1;
			end
			ST_FORMAT: begin
				if (c < 4)
					tag_sr = {tag_sr[23:0], b};
				else if (c < 8)
					len_acc = place_byte(len_acc, b, c - 4);
				else if (c < 10) begin
					tmp = place_byte({16'h0, fmt_code}, b, c - 8); fmt_code = tmp[15:0];
				end else if (c < 12) begin
					tmp = place_byte({16'h0, chan_cnt}, b, c - 10); chan_cnt = tmp[15:0];
				end else if (c < 16)
					rate_val = place_byte(rate_val, b, c - 12);
				else if (c >= 22) begin
					tmp = place_byte({16'h0, bits_val}, b, c - 22); bits_val = tmp[15:0];
				end
				// tag first, then the format code, once all 24 bytes are in
				if (c >= 23) begin
					field_cnt = '0;
					if (tag_sr != TAG_FMT) begin
						got = 1'b1; r.kind = KIND_ERROR; r.error_code = ERR_NO_FMT;
						st  = ST_ERROR;
					end else if (fmt_code != FMT_PCM) begin
						got = 1'b1; r.kind = KIND_ERROR; r.error_code = ERR_NOT_PCM;
						st  = ST_ERROR;
					end else if (len_acc > FMT_BASE_LEN) begin
						remain = len_acc - FMT_BASE_LEN;
						st     = ST_SKIP;
					end else
						st = ST_CHUNK_HDR;
				end else
					field_cnt = c + 5'd1;
			end
			ST_SKIP: begin
				if (remain > 0)
					remain = remain - 1;
				if (remain == 0) begin
					st        = ST_CHUNK_HDR;
					field_cnt = '0;
				end
			end
			ST_CHUNK_HDR: begin
				if (c < 4)
					tag_sr = {tag_sr[23:0], b};
				else
					len_acc = place_byte(len_acc, b, (c - 4) & 3);
				if (c >= 7) begin
					field_cnt = '0;
					if (tag_sr == TAG_DATA) begin
						if (bits_val == DEPTH_8 || bits_val == DEPTH_16) begin
							got             = 1'b1;
							r.kind          = KIND_INFO;
							r.sample_rate   = rate_val;
							r.channel_count = chan_cnt[7:0];
							r.sample_bits   = bits_val[7:0];
							remain          = len_acc;
							st              = (len_acc == 0) ? ST_DONE : ST_DATA;
						end else begin
							got = 1'b1; r.kind = KIND_ERROR; r.error_code = ERR_DEPTH;
							st  = ST_ERROR;
						end
					end else if (len_acc > 0) begin
						// unknown chunk: skip its body; zero length goes straight to the next header
						remain = len_acc;
						st     = ST_SKIP;
					end
				end else
					field_cnt = c + 5'd1;
			end
			ST_DATA: begin
				if (remain > 0)
					remain = remain - 1;
				if (bits_val == DEPTH_8) begin
					got = 1'b1; r.kind = KIND_SAMPLE; r.sample = {b ^ 8'h80, 8'h00};
				end else if (c == 0) begin
					low_byte  = b;
					field_cnt = 5'd1;
				end else begin
					got = 1'b1; r.kind = KIND_SAMPLE; r.sample = {b, low_byte};
					field_cnt = '0;
				end
				// an odd trailing byte of 16-bit data is simply dropped here
				if (remain == 0) begin
					st        = ST_DONE;
					field_cnt = '0;
				end
			end
			default: begin
			end
		endcase

		if (eof) begin
			// the last byte always reports; format info gives way to the end item
			if (!got || r.kind == KIND_INFO) begin
				r   = '0;
				got = 1'b1;
				case (st)
					ST_HEADER:              begin r.kind = KIND_ERROR; r.error_code = ERR_RIFF; end
					ST_FORMAT:              begin r.kind = KIND_ERROR; r.error_code = ERR_NO_FMT; end
					ST_SKIP, ST_CHUNK_HDR:  begin r.kind = KIND_ERROR; r.error_code = ERR_NO_DATA; end
					default:                r.kind = KIND_END;
				endcase
			end
			r.last = 1'b1;
			clear_parse_state();
		end
		return got;
	endfunction

	// ------------------------------------------------------------------
	// Expected results and run statistics
	// ------------------------------------------------------------------
	wav_out_t pending_results[$];
	int       n_fail    = 0;
	int       n_bytes   = 0;
	int       n_files   = 0;
	int       n_checked = 0;
	int       kind_seen[4];
	int       burst_left = 0;
	logic [7:0] file_bytes[$];

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------

	// Drive one request at the falling edge, hold it until accepted, then predict.
	task automatic send_byte(input logic [7:0] b, input logic eof);
		wav_out_t r;
		@(negedge clk);
		byte_valid          <= 1'b1;
		byte_req.data_byte   <= b;
		byte_req.end_of_file <= eof;
		do
			@(posedge clk);
		while (!byte_ready);
		n_bytes++;
		if (predict_result(b, eof, r))
			pending_results.push_back(r);
	endtask

	// Drop valid and stay idle; n gives the length of the gap.
	task automatic idle_cycles(input int n);
		repeat (n) begin
			@(negedge clk);
			byte_valid <= 1'b0;
		end
	endtask

	// Hold off new requests until every outstanding result has been taken.
	task automatic drain_results();
		idle_cycles(1);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Send file_bytes as one file, flagging the last byte. Requests go out in
	// bursts; pause_at >= 0 drains all results before that byte.
	task automatic stream_file(input int pause_at);
		int gap;
		for (int i = 0; i < file_bytes.size(); i++) begin
			if (i == pause_at)
				drain_results();
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 48);
				gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				idle_cycles(gap);
			end
			burst_left--;
			send_byte(file_bytes[i], i == file_bytes.size() - 1);
		end
		n_files++;
	endtask

	// ------------------------------------------------------------------
	// File builders
	// ------------------------------------------------------------------
	function automatic void put_tag(input logic [31:0] t);
		for (int i = 3; i >= 0; i--)
			file_bytes.push_back(t[8*i +: 8]);
	endfunction

	function automatic void put_le(input logic [31:0] v, input int n);
		for (int i = 0; i < n; i++)
			file_bytes.push_back(v[8*i +: 8]);
	endfunction

	function automatic void trim_file(input int n);
		file_bytes = file_bytes[0:n-1];
	endfunction

	// Build a RIFF/WAVE file: fmt chunk (extra bytes when fmt_len > 16), n_junk
	// unknown chunks, then a data chunk declaring data_len with n_data random bytes.
	function automatic void build_wav(input logic [15:0] fcode, input logic [15:0] depth,
			input logic [15:0] chans, input logic [31:0] rate, input logic [31:0] fmt_len,
			input int n_junk, input logic [31:0] data_len, input int n_data);
		int jlen;
		file_bytes.delete();
		put_tag(TAG_RIFF);
		put_le($urandom, 4);
		put_tag(TAG_WAVE);
		put_tag(TAG_FMT);
		put_le(fmt_len, 4);
		put_le(32'(fcode), 2);
		put_le(32'(chans), 2);
		put_le(rate, 4);
		put_le($urandom, 4);
		put_le($urandom, 2);
		put_le(32'(depth), 2);
		if (fmt_len > FMT_BASE_LEN)
			repeat (fmt_len - FMT_BASE_LEN)
				file_bytes.push_back(8'($urandom));
		repeat (n_junk) begin
			jlen = $urandom_range(0, 6);
			put_tag($urandom);
			put_le(jlen, 4);
			repeat (jlen)
				file_bytes.push_back(8'($urandom));
		end
		put_tag(TAG_DATA);
		put_le(data_len, 4);
		repeat (n_data)
			file_bytes.push_back(8'($urandom));
	endfunction

	// Build a mostly well-formed file with random format fields and contents.
	function automatic void build_random_wav();
		logic [15:0] fcode, depth, chans;
		logic [31:0] rate, fmt_len, data_len;
		int          pick, n_data;
		fcode = ($urandom_range(0, 9) == 0) ? 16'($urandom) : FMT_PCM;
		pick  = $urandom_range(0, 99);
		depth = (pick < 40) ? DEPTH_8 : (pick < 85) ? DEPTH_16 : 16'($urandom_range(0, 40));
		chans = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 2));
		case ($urandom_range(0, 3))
			0:       rate = 32'd8000;
			1:       rate = 32'd44100;
			2:       rate = 32'd48000;
			default: rate = $urandom;
		endcase
		pick    = $urandom_range(0, 9);
		fmt_len = (pick < 5) ? FMT_BASE_LEN : (pick < 8) ? 32'($urandom_range(17, 22))
			: 32'($urandom_range(0, 15));
		data_len = $urandom_range(0, 40);
		// sometimes the file ends inside the data, else stray bytes may follow it
		n_data = ($urandom_range(0, 4) == 0) ? $urandom_range(0, data_len)
			: data_len + $urandom_range(0, 3);
		build_wav(fcode, depth, chans, rate, fmt_len, $urandom_range(0, 2), data_len, n_data);
	endfunction

	// ------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------

	// Result consumer: cycle through always-ready, random and periodic stalls.
	logic [9:0] stall_cycle = '0;
	always @(negedge clk) begin
		stall_cycle <= stall_cycle + 10'd1;
		case (stall_cycle[9:8])
			2'd0:    result_ready <= 1'b1;
			2'd1:    result_ready <= 1'($urandom_range(0, 1));
			2'd2:    result_ready <= (stall_cycle[1:0] == 2'd0);
			default: result_ready <= ($urandom_range(0, 7) != 0);
		endcase
	end

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name,
				want, got);
			n_fail++;
		end
	endfunction

	// Compare each taken result with the oldest expectation.
	always @(posedge clk) begin : result_check
		wav_out_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual %p", $time, result);
				n_fail++;
			end else begin
				want = pending_results.pop_front();
				check_field("kind",          32'(want.kind),          32'(result.kind));
				check_field("sample",        32'(want.sample),        32'(result.sample));
				check_field("sample_rate",   want.sample_rate,        result.sample_rate);
				check_field("channel_count", 32'(want.channel_count), 32'(result.channel_count));
				check_field("sample_bits",   32'(want.sample_bits),   32'(result.sample_bits));
				check_field("error_code",    32'(want.error_code),    32'(result.error_code));
				check_field("last",          32'(want.last),          32'(result.last));
				n_checked++;
				kind_seen[want.kind]++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Valid files: sample extremes at both depths, skipped fmt bytes, odd
	// 16-bit tail, empty data chunk, end on the data header, short fmt chunk.
	task automatic test_pcm_formats();
		build_wav(FMT_PCM, DEPTH_8, 16'd1, 32'd8000, FMT_BASE_LEN, 0, 32'd4, 0);
		file_bytes.push_back(8'h00); file_bytes.push_back(8'h80);
		file_bytes.push_back(8'hFF); file_bytes.push_back(8'h7F);
		stream_file(-1);
		// last byte is an odd tail: dropped, so the file closes with an end item
		build_wav(FMT_PCM, DEPTH_16, 16'd2, 32'hFFFF_FFFF, 32'd18, 1, 32'd5, 0);
		file_bytes.push_back(8'h00); file_bytes.push_back(8'h80);
		file_bytes.push_back(8'hFF); file_bytes.push_back(8'h7F);
		file_bytes.push_back(8'h11);
		stream_file(-1);
		build_wav(FMT_PCM, DEPTH_16, 16'h01FF, 32'd0, FMT_BASE_LEN, 0, 32'd0, 3);
		stream_file(-1);
		build_wav(FMT_PCM, DEPTH_8, 16'd1, 32'd44100, FMT_BASE_LEN, 0, 32'd8, 0);
		stream_file(-1);
		build_wav(FMT_PCM, DEPTH_8, 16'hFFFF, 32'd48000, 32'd14, 2, 32'd3, 3);
		stream_file(-1);
	endtask

	// RIFF, fmt, PCM and depth errors raised by bad header fields, plus a lone final byte.
	task automatic test_header_errors();
		build_wav(FMT_PCM, DEPTH_8, 16'd1, 32'd8000, FMT_BASE_LEN, 0, 32'd2, 2);
		file_bytes[0] = 8'h72;
		stream_file(-1);
		build_wav(FMT_PCM, DEPTH_8, 16'd1, 32'd8000, FMT_BASE_LEN, 0, 32'd2, 2);
		file_bytes[8] ^= 8'h01;
		stream_file(-1);
		build_wav(FMT_PCM, DEPTH_8, 16'd1, 32'd8000, FMT_BASE_LEN, 0, 32'd2, 2);
		file_bytes[15] = 8'h21;
		stream_file(-1);
		build_wav(16'd3, DEPTH_16, 16'd1, 32'd8000, FMT_BASE_LEN, 0, 32'd2, 2);
		stream_file(-1);
		build_wav(FMT_PCM, 16'd24, 16'd1, 32'd8000, FMT_BASE_LEN, 1, 32'd2, 2);
		stream_file(-1);
		file_bytes.delete();
		file_bytes.push_back(8'hFF);
		stream_file(-1);
	endtask

	// Files cut short in the header, fmt chunk, fmt skip, chunk header and data.
	task automatic test_early_end();
		build_wav(FMT_PCM, DEPTH_8, 16'd1, 32'd8000, FMT_BASE_LEN, 0, 32'd2, 2);
		trim_file(6);
		stream_file(-1);
		build_wav(FMT_PCM, DEPTH_8, 16'd1, 32'd8000, FMT_BASE_LEN, 0, 32'd2, 2);
		trim_file(20);
		stream_file(-1);
		build_wav(FMT_PCM, DEPTH_8, 16'd1, 32'd8000, 32'd20, 0, 32'd2, 2);
		trim_file(38);
		stream_file(-1);
		build_wav(FMT_PCM, DEPTH_8, 16'd1, 32'd8000, FMT_BASE_LEN, 0, 32'd2, 2);
		trim_file(40);
		stream_file(-1);
		// ends on a completed 16-bit sample, which becomes the last result
		build_wav(FMT_PCM, DEPTH_16, 16'd2, 32'd22050, FMT_BASE_LEN, 0, 32'd10, 10);
		trim_file(file_bytes.size() - 4);
		stream_file(-1);
		build_wav(FMT_PCM, DEPTH_8, 16'd1, 32'd22050, FMT_BASE_LEN, 0, 32'd10, 3);
		stream_file(-1);
	endtask

	// Hold off mid-file until the result queue is empty, then carry on.
	task automatic test_drain_pause();
		build_wav(FMT_PCM, DEPTH_16, 16'd2, 32'd44100, 32'd17, 1, 32'd16, 16);
		stream_file(file_bytes.size() - 8);
	endtask

	// Random files: mostly well-formed, some with a flipped header byte,
	// some truncated, some pure noise.
	task automatic test_random_files(input int n_target);
		int stop_at, pick, pos, pause;
		stop_at = n_bytes + n_target;
		while (n_bytes < stop_at) begin
			build_random_wav();
			pick = $urandom_range(0, 99);
			if (pick >= 90) begin
				file_bytes.delete();
				repeat ($urandom_range(1, 24))
					file_bytes.push_back(8'($urandom));
			end else if (pick >= 75)
				trim_file($urandom_range(1, file_bytes.size()));
			else if (pick >= 60) begin
				pos = $urandom_range(0, (file_bytes.size() < 48 ? file_bytes.size() : 48) - 1);
				file_bytes[pos] ^= 8'(1 << $urandom_range(0, 7));
			end
			pause = ($urandom_range(0, 7) == 0) ? $urandom_range(0, file_bytes.size() - 1) : -1;
			stream_file(pause);
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		clear_parse_state();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_pcm_formats();
		test_header_errors();
		test_early_end();
		test_drain_pause();
		test_random_files(1100);

		// drain, then leave room for any stray result
		drain_results();
		repeat (8) @(posedge clk);

		$display("Streamed %0d byte requests in %0d files, checked %0d results.",
			n_bytes, n_files, n_checked);
		$display("Results seen: %0d samples, %0d format, %0d errors, %0d end of file.",
			kind_seen[KIND_SAMPLE], kind_seen[KIND_INFO], kind_seen[KIND_ERROR],
			kind_seen[KIND_END]);
		if (n_fail == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("Timeout with %0d results outstanding", pending_results.size());
		$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire

@@ wav_pcm_stream_parser.f @@
src/wavp_pkg.sv
src/wavp_parse.sv
src/wav_pcm_stream_parser.sv
src/wavp_checker.sv
dv/tb_top.sv
